FILE: hw/rtl/hgrp_pkg.sv
// Shared types, codes and literals of the HTTP GET request line parser.
package hgrp_pkg;

   localparam int MAX_PATH_DEFAULT = 256;

   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int KIND_W     = 2;
   localparam int PATH_LEN_W = 9;
   localparam int LIT_IDX_W  = 3;
   localparam int WINDOW_W   = 40;
   localparam int ROOT_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from the word address
   localparam logic CSR_ROOT_PREFIX_LEN = 1'b0;

   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [39:0] SUFFIX_HTML = 40'h2E68746D6C;
   localparam logic [31:0] SUFFIX_CSS  = 32'h2E637373;
   localparam logic [23:0] SUFFIX_JS   = 24'h2E6A73;
   localparam int HTML_LEN = 5;
   localparam int CSS_LEN  = 4;
   localparam int JS_LEN   = 3;

   localparam logic [LIT_IDX_W-1:0] METHOD_LAST_IDX  = 3'd3;
   localparam logic [LIT_IDX_W-1:0] VERSION_FIRST_IDX = 3'd1;
   localparam logic [LIT_IDX_W-1:0] VERSION_LAST_IDX = 3'd6;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_PATH,
      PH_VERSION,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NOT_GET,
      ST_BAD_PATH,
      ST_NOT_HTTP
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HTML,
      KIND_JS,
      KIND_CSS,
      KIND_BIN
   } kind_type;

   typedef struct packed {
      status_type              status;
      kind_type                content_kind;
      logic [PATH_LEN_W-1:0]   path_length;
   } result_type;

   // "GET "
   function automatic logic [BYTE_W-1:0] method_char(input logic [LIT_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h47;
         3'd1:    c = 8'h45;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // " HTTP/1"
   function automatic logic [BYTE_W-1:0] version_char(input logic [LIT_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h20;
         3'd1:    c = 8'h48;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h54;
         3'd4:    c = 8'h50;
         3'd5:    c = 8'h2F;
         3'd6:    c = 8'h31;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/hgrp_if.sv
// Request and result channel interfaces of the request line parser.
interface hgrp_req_if;
   logic                       valid;
   logic                       ready;
   logic [hgrp_pkg::BYTE_W-1:0] data_byte;
   logic                       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface hgrp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hgrp_pkg::STATUS_W-1:0]   status;
   logic [hgrp_pkg::KIND_W-1:0]     content_kind;
   logic [hgrp_pkg::PATH_LEN_W-1:0] path_length;

   modport source (output valid, output status, output content_kind, output path_length,
                   input ready);
   modport sink (input valid, input status, input content_kind, input path_length,
                 output ready);
endinterface

FILE: hw/rtl/hgrp_core.sv
// Byte-wise request line checker: phase, literal match, path count and suffix window.
module hgrp_core #(
   parameter int MAX_PATH = hgrp_pkg::MAX_PATH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [hgrp_pkg::BYTE_W-1:0]       data_byte,
   input  logic                              last,
   input  logic [hgrp_pkg::ROOT_W-1:0]       root_prefix_len,
   output hgrp_pkg::result_type              result
);

   localparam int CNT_W = $clog2(MAX_PATH + 1);
   localparam int SUM_W = ((CNT_W > hgrp_pkg::ROOT_W) ? CNT_W : hgrp_pkg::ROOT_W) + 1;
   localparam int EXT_W = (CNT_W > hgrp_pkg::PATH_LEN_W) ? CNT_W : hgrp_pkg::PATH_LEN_W;

   hgrp_pkg::phase_type                phase_ff, phase_in;
   logic [hgrp_pkg::LIT_IDX_W-1:0]     lit_idx_ff, lit_idx_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [hgrp_pkg::WINDOW_W-1:0]      window_ff, window_in;
   hgrp_pkg::status_type               verdict_ff, verdict_in;
   hgrp_pkg::kind_type                 kind_ff, kind_in;

   logic [SUM_W-1:0]                   count_x;
   logic [SUM_W-1:0]                   span;
   logic                               hit_html, hit_js, hit_css;
   hgrp_pkg::kind_type                 kind_pick;
   hgrp_pkg::status_type               end_status;
   logic [EXT_W-1:0]                   len_x;

   // suffix must fit inside the path and be shorter than root plus path
   assign count_x  = SUM_W'(count_ff);
   assign span     = count_x + SUM_W'(root_prefix_len);
   assign hit_html = (span > SUM_W'(hgrp_pkg::HTML_LEN)) &&
                     (count_x >= SUM_W'(hgrp_pkg::HTML_LEN)) &&
                     (window_ff == hgrp_pkg::SUFFIX_HTML);
   assign hit_js   = (span > SUM_W'(hgrp_pkg::JS_LEN)) &&
                     (count_x >= SUM_W'(hgrp_pkg::JS_LEN)) &&
                     (window_ff[23:0] == hgrp_pkg::SUFFIX_JS);
   assign hit_css  = (span > SUM_W'(hgrp_pkg::CSS_LEN)) &&
                     (count_x >= SUM_W'(hgrp_pkg::CSS_LEN)) &&
                     (window_ff[31:0] == hgrp_pkg::SUFFIX_CSS);

   always_comb begin
      if (hit_html) begin
         kind_pick = hgrp_pkg::KIND_HTML;
      end else if (hit_js) begin
         kind_pick = hgrp_pkg::KIND_JS;
      end else if (hit_css) begin
         kind_pick = hgrp_pkg::KIND_CSS;
      end else begin
         kind_pick = hgrp_pkg::KIND_BIN;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      lit_idx_in = lit_idx_ff;
      count_in   = count_ff;
      window_in  = window_ff;
      verdict_in = verdict_ff;
      kind_in    = kind_ff;
      case (phase_ff)
         hgrp_pkg::PH_METHOD: begin
            if (data_byte != hgrp_pkg::method_char(lit_idx_ff)) begin
               verdict_in = hgrp_pkg::ST_NOT_GET;
               phase_in   = hgrp_pkg::PH_FAIL;
            end else if (lit_idx_ff >= hgrp_pkg::METHOD_LAST_IDX) begin
               phase_in   = hgrp_pkg::PH_PATH;
               lit_idx_in = '0;
            end else begin
               lit_idx_in = lit_idx_ff + 1'b1;
            end
         end
         hgrp_pkg::PH_PATH: begin
            if (data_byte == hgrp_pkg::CHAR_SPACE) begin
               if (count_ff == '0) begin
                  verdict_in = hgrp_pkg::ST_BAD_PATH;
                  phase_in   = hgrp_pkg::PH_FAIL;
               end else begin
                  kind_in    = kind_pick;
                  phase_in   = hgrp_pkg::PH_VERSION;
                  lit_idx_in = hgrp_pkg::VERSION_FIRST_IDX;
               end
            end else if (count_ff >= CNT_W'(MAX_PATH)) begin
               count_in   = CNT_W'(MAX_PATH);
               verdict_in = hgrp_pkg::ST_BAD_PATH;
               phase_in   = hgrp_pkg::PH_FAIL;
            end else begin
               count_in  = count_ff + 1'b1;
               window_in = {window_ff[hgrp_pkg::WINDOW_W-hgrp_pkg::BYTE_W-1:0], data_byte};
            end
         end
         hgrp_pkg::PH_VERSION: begin
            if (data_byte != hgrp_pkg::version_char(lit_idx_ff)) begin
               verdict_in = hgrp_pkg::ST_NOT_HTTP;
               phase_in   = hgrp_pkg::PH_FAIL;
            end else if (lit_idx_ff >= hgrp_pkg::VERSION_LAST_IDX) begin
               phase_in   = hgrp_pkg::PH_DONE;
               verdict_in = hgrp_pkg::ST_OK;
            end else begin
               lit_idx_in = lit_idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // status of a buffer that ends here, taken from the updated state
   always_comb begin
      case (phase_in)
         hgrp_pkg::PH_METHOD:  end_status = hgrp_pkg::ST_NOT_GET;
         hgrp_pkg::PH_PATH:    end_status = (count_in == '0) ? hgrp_pkg::ST_BAD_PATH
                                                            : hgrp_pkg::ST_NOT_HTTP;
         hgrp_pkg::PH_VERSION: end_status = hgrp_pkg::ST_NOT_HTTP;
         hgrp_pkg::PH_DONE:    end_status = hgrp_pkg::ST_OK;
         default:              end_status = verdict_in;
      endcase
   end

   assign len_x               = EXT_W'(count_in);
   assign result.status       = end_status;
   assign result.content_kind = (end_status == hgrp_pkg::ST_OK) ? kind_in : hgrp_pkg::KIND_HTML;
   assign result.path_length  = len_x[hgrp_pkg::PATH_LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hgrp_pkg::PH_METHOD;
         lit_idx_ff <= '0;
         count_ff   <= '0;
         window_ff  <= '0;
         verdict_ff <= hgrp_pkg::ST_OK;
         kind_ff    <= hgrp_pkg::KIND_HTML;
      end else if (step) begin
         if (last) begin
            // start afresh for the next request
            phase_ff   <= hgrp_pkg::PH_METHOD;
            lit_idx_ff <= '0;
            count_ff   <= '0;
            window_ff  <= '0;
            verdict_ff <= hgrp_pkg::ST_OK;
            kind_ff    <= hgrp_pkg::KIND_HTML;
         end else begin
            phase_ff   <= phase_in;
            lit_idx_ff <= lit_idx_in;
            count_ff   <= count_in;
            window_ff  <= window_in;
            verdict_ff <= verdict_in;
            kind_ff    <= kind_in;
         end
      end
   end

endmodule

FILE: hw/rtl/http_get_request_line_parser.sv
// A request byte is first captured in the input register; on a last byte, its result
// is then loaded from hgrp_core into the result register.
// Throughput: one byte per cycle, set by the single-pass byte step in hgrp_core.
// A stalled result register holds back a last byte, and the bytes after it wait in turn.
// Reset (synchronous, active high) empties both registers, returns the checker to the
// method phase and clears root_prefix_len to 0.
module http_get_request_line_parser #(
   parameter int MAX_PATH = hgrp_pkg::MAX_PATH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hgrp_req_if.sink                             req,
   hgrp_rsp_if.source                           rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [hgrp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [hgrp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [hgrp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   logic                              in_valid_ff;
   logic [hgrp_pkg::BYTE_W-1:0]       in_byte_ff;
   logic                              in_last_ff;
   logic                              advance;

   logic                              rsp_valid_ff;
   hgrp_pkg::result_type              rsp_ff;
   hgrp_pkg::result_type              core_result;

   logic [hgrp_pkg::ROOT_W-1:0]       root_len_ff;
   logic                              csr_hit;

   // a last byte waits until the result register is free or being emptied
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last;
      end
   end

   hgrp_core #(
      .MAX_PATH (MAX_PATH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .data_byte       (in_byte_ff),
      .last            (in_last_ff),
      .root_prefix_len (root_len_ff),
      .result          (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_ff.status;
   assign rsp.content_kind = rsp_ff.content_kind;
   assign rsp.path_length  = rsp_ff.path_length;

   // register bank: one register at word address zero
   assign csr_hit = (paddr[hgrp_pkg::CSR_ADDR_W-1] == hgrp_pkg::CSR_ROOT_PREFIX_LEN);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_len_ff <= '0;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         root_len_ff <= pwdata[hgrp_pkg::ROOT_W-1:0];
      end
   end

   assign prdata = csr_hit ? hgrp_pkg::CSR_DATA_W'(root_len_ff) : '0;

endmodule

FILE: sim/http_get_request_line_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the HTTP GET request line parser: directed and random requests.
module http_get_request_line_parser_tb;

   localparam int MAX_PATH = hgrp_pkg::MAX_PATH_DEFAULT;
   localparam logic [hgrp_pkg::CSR_ADDR_W-1:0] ROOT_PREFIX_ADDR =
      {hgrp_pkg::CSR_ROOT_PREFIX_LEN, 2'b00};
   localparam logic [7:0] SPACE = 8'h20;
   localparam int METHOD_END_POS = 3;
   localparam int VERSION_START_POS = 1;
   localparam int VERSION_END_POS = 6;
   localparam logic [0:7][7:0] GET_TEXT =
      {8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [0:7][7:0] HTTP_TEXT =
      {8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h00};
   localparam int RANDOM_BYTES = 700;
   localparam int DRAIN_LIMIT = 20000;

   typedef logic [7:0] byte_queue_type[$];

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [hgrp_pkg::CSR_ADDR_W-1:0] paddr;
   logic [hgrp_pkg::CSR_DATA_W-1:0] pwdata;
   logic [hgrp_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   hgrp_req_if req_bus ();
   hgrp_rsp_if rsp_bus ();

   http_get_request_line_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus.sink),
      .rsp     (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // parser state as predicted
   logic [hgrp_pkg::ROOT_W-1:0] root_len;
   hgrp_pkg::phase_type         parse_phase;
   int                          lit_pos;
   int                          path_cnt;
   logic [39:0]                 path_tail;
   hgrp_pkg::status_type        failed_as;
   hgrp_pkg::kind_type          kind_seen;

   hgrp_pkg::result_type awaited_results[$];

   int fault_count = 0;
   int bytes_sent = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int root_settings = 0;
   int req_idle_pct = 37;
   int rsp_idle_pct = 37;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Run timed out");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_fault(input string what, input int want, input int got);
      fault_count++;
      if (fault_count <= 10)
         $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   function automatic void clear_parse_state();
      parse_phase = hgrp_pkg::PH_METHOD;
      lit_pos = 0;
      path_cnt = 0;
      path_tail = '0;
      failed_as = hgrp_pkg::ST_OK;
      kind_seen = hgrp_pkg::KIND_HTML;
   endfunction

   function automatic bit path_ends_with(input int ext_len, input logic [39:0] pattern);
      logic [39:0] mask;
      mask = (40'd1 << (8 * ext_len)) - 40'd1;
      // the root prefix only counts towards the length test
      if (int'(root_len) + path_cnt <= ext_len) return 1'b0;
      if (path_cnt < ext_len) return 1'b0;
      return (path_tail & mask) == pattern;
   endfunction

   function automatic hgrp_pkg::kind_type content_kind_of_path();
      if (path_ends_with(5, 40'h2E68746D6C)) return hgrp_pkg::KIND_HTML;
      if (path_ends_with(3, 40'h00002E6A73)) return hgrp_pkg::KIND_JS;
      if (path_ends_with(4, 40'h002E637373)) return hgrp_pkg::KIND_CSS;
      return hgrp_pkg::KIND_BIN;
   endfunction

   function automatic void parse_request_byte(input logic [7:0] b, input logic is_last);
      hgrp_pkg::result_type r;
      case (parse_phase)
         hgrp_pkg::PH_METHOD: begin
            if (b != GET_TEXT[lit_pos]) begin
               failed_as = hgrp_pkg::ST_NOT_GET;
               parse_phase = hgrp_pkg::PH_FAIL;
            end else if (lit_pos >= METHOD_END_POS) begin
               parse_phase = hgrp_pkg::PH_PATH;
               lit_pos = 0;
            end else begin
               lit_pos++;
            end
         end
         hgrp_pkg::PH_PATH: begin
            if (b == SPACE) begin
               if (path_cnt == 0) begin
                  failed_as = hgrp_pkg::ST_BAD_PATH;
                  parse_phase = hgrp_pkg::PH_FAIL;
               end else begin
                  kind_seen = content_kind_of_path();
                  parse_phase = hgrp_pkg::PH_VERSION;
                  lit_pos = VERSION_START_POS;
               end
            end else if (path_cnt >= MAX_PATH) begin
               path_cnt = MAX_PATH;
               failed_as = hgrp_pkg::ST_BAD_PATH;
               parse_phase = hgrp_pkg::PH_FAIL;
            end else begin
               path_cnt++;
               path_tail = {path_tail[31:0], b};
            end
         end
         hgrp_pkg::PH_VERSION: begin
            if (b != HTTP_TEXT[lit_pos]) begin
               failed_as = hgrp_pkg::ST_NOT_HTTP;
               parse_phase = hgrp_pkg::PH_FAIL;
            end else if (lit_pos >= VERSION_END_POS) begin
               parse_phase = hgrp_pkg::PH_DONE;
            end else begin
               lit_pos++;
            end
         end
         default: ;
      endcase
      if (is_last) begin
         case (parse_phase)
            hgrp_pkg::PH_METHOD:  r.status = hgrp_pkg::ST_NOT_GET;
            hgrp_pkg::PH_PATH:    r.status = (path_cnt == 0) ? hgrp_pkg::ST_BAD_PATH
                                                             : hgrp_pkg::ST_NOT_HTTP;
            hgrp_pkg::PH_VERSION: r.status = hgrp_pkg::ST_NOT_HTTP;
            hgrp_pkg::PH_DONE:    r.status = hgrp_pkg::ST_OK;
            default:              r.status = failed_as;
         endcase
         r.content_kind = (r.status == hgrp_pkg::ST_OK) ? kind_seen : hgrp_pkg::KIND_HTML;
         r.path_length = hgrp_pkg::PATH_LEN_W'((path_cnt > MAX_PATH) ? MAX_PATH : path_cnt);
         awaited_results.push_back(r);
         clear_parse_state();
      end
   endfunction

   // Leaves valid high on return, so a following byte goes out back to back.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parse_request_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic send_request(input byte_queue_type msg);
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
      requests_sent++;
   endtask

   function automatic void add_text(ref byte_queue_type msg, input string s);
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      byte_queue_type msg;
      add_text(msg, s);
      send_request(msg);
   endtask

   task automatic send_long_path(input int n);
      byte_queue_type msg;
      add_text(msg, "GET /");
      repeat (n - 1) msg.push_back(8'h61);
      add_text(msg, " HTTP/1");
      send_request(msg);
   endtask

   // Drop valid and let every awaited result arrive, with a drain limit as a guard.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && awaited_results.size() != 0; n++)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_root_prefix(input logic [7:0] value);
      wait_until_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ROOT_PREFIX_ADDR;
      pwdata <= hgrp_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      root_len = value;
      root_settings++;
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[hgrp_pkg::ROOT_W-1:0] !== value)
         report_fault("root_prefix_len read", value, prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      hgrp_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            report_fault("unexpected result, status", -1, rsp_bus.status);
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (rsp_bus.status !== want.status)
               report_fault("status", want.status, rsp_bus.status);
            if (rsp_bus.content_kind !== want.content_kind)
               report_fault("content_kind", want.content_kind, rsp_bus.content_kind);
            if (rsp_bus.path_length !== want.path_length)
               report_fault("path_length", want.path_length, rsp_bus.path_length);
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic test_method_checks();
      byte_queue_type msg;
      write_root_prefix(8'd0);
      send_text("GET /a HTTP/1");
      send_text("POST /a HTTP/1");
      send_text("get /a HTTP/1");
      send_text("G");
      send_text("GE");
      msg = {8'h00, 8'h47, 8'h45, 8'h54};
      send_request(msg);
      msg = {8'hFF};
      send_request(msg);
   endtask

   task automatic test_path_checks();
      byte_queue_type msg;
      send_text("GET  HTTP/1");
      send_text("GET ");
      send_text("GET /abc");
      send_long_path(MAX_PATH);
      send_long_path(MAX_PATH + 1);
      // zero and all-ones bytes are ordinary path bytes
      add_text(msg, "GET /");
      msg.push_back(8'h00);
      msg.push_back(8'hFF);
      add_text(msg, ".js HTTP/1");
      send_request(msg);
   endtask

   task automatic test_version_checks();
      send_text("GET /a HTTP/2");
      send_text("GET /a HT");
      send_text("GET /a http/1");
      send_text("GET /a HTTP/1.1\r\n");
      send_text("GET /a HTTP/1 GET /b x");
   endtask

   task automatic test_content_kinds();
      send_text("GET /index.html HTTP/1.1");
      send_text("GET /app.js HTTP/1");
      send_text("GET /site.css HTTP/1");
      send_text("GET /x.HTML HTTP/1");
      send_text("GET /a.htm HTTP/1");
      send_text("GET /y.css.js HTTP/1");
      send_text("GET .js HTTP/1");
   endtask

   task automatic test_root_prefix();
      write_root_prefix(8'd1);
      send_text("GET .js HTTP/1");
      send_text("GET .css HTTP/1");
      send_text("GET js HTTP/1");
      write_root_prefix(8'd255);
      send_text("GET .html HTTP/1");
      send_text("GET tml HTTP/1");
   endtask

   task automatic test_result_backpressure();
      write_root_prefix(8'd2);
      // hold the result side so the block fills up and stalls its input
      hold_left = 300;
      repeat (6) begin
         send_text("GET /a.js HTTP/1");
         send_text("GE");
      end
      wait_until_idle();
   endtask

   task automatic send_random_request();
      byte_queue_type msg;
      int pick, plen, pos;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 12) begin
         if ($urandom_range(1)) add_text(msg, "GE");
         repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
      end else begin
         add_text(msg, "GET ");
         plen = ($urandom_range(99) < 4) ? $urandom_range(250, 262) : $urandom_range(0, 10);
         repeat (plen) begin
            b = 8'($urandom_range(255));
            msg.push_back((b == SPACE) ? 8'h21 : b);
         end
         case ($urandom_range(5))
            0: add_text(msg, ".html");
            1: add_text(msg, ".js");
            2: add_text(msg, ".css");
            3: add_text(msg, ".htm");
            4: add_text(msg, ".JS");
            default: ;
         endcase
         add_text(msg, " HTTP/1");
         repeat ($urandom_range(3)) msg.push_back(8'($urandom_range(255)));
         if (pick < 22) begin
            // end the buffer early
            pos = $urandom_range(1, msg.size() - 1);
            while (msg.size() > pos) void'(msg.pop_back());
         end else if (pick < 32) begin
            pos = $urandom_range(msg.size() - 1);
            msg[pos] = 8'($urandom_range(255));
         end
      end
      send_request(msg);
   endtask

   task automatic test_random_traffic();
      int target, next_setting;
      target = bytes_sent + RANDOM_BYTES;
      next_setting = bytes_sent + 400;
      while (bytes_sent < target) begin
         if (bytes_sent >= next_setting) begin
            write_root_prefix(8'($urandom_range(255)));
            next_setting = bytes_sent + 400;
            // one stretch with no idling on either side
            req_idle_pct = (req_idle_pct == 0) ? 37 : 0;
            rsp_idle_pct = req_idle_pct;
         end
         send_random_request();
      end
      req_idle_pct = 37;
      rsp_idle_pct = 37;
      write_root_prefix(8'd0);
      repeat (10) send_random_request();
   endtask

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last <= 1'b0;
      root_len = '0;
      clear_parse_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_method_checks();
      test_path_checks();
      test_version_checks();
      test_content_kinds();
      test_root_prefix();
      test_result_backpressure();
      test_random_traffic();

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (awaited_results.size() != 0)
         report_fault("results still awaited", 0, awaited_results.size());
      $display("Sent %0d requests (%0d bytes) under %0d root prefix settings",
               requests_sent, bytes_sent, root_settings);
      $display("Checked %0d results, %0d faults", results_checked, fault_count);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: http_get_request_line_parser.f
hw/rtl/hgrp_pkg.sv
hw/rtl/hgrp_if.sv
hw/rtl/hgrp_core.sv
hw/rtl/http_get_request_line_parser.sv
sim/http_get_request_line_parser_tb.sv
